// ----- rtl/core/hhmm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes, constants and font table for the HH:MM clock core.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
package hhmm_pkg;

  typedef enum logic [2:0] {
    REQ_MIN_TICK = 3'd0,
    REQ_HOUR_BTN = 3'd1,
    REQ_MIN_BTN  = 3'd2,
    REQ_SWEEP    = 3'd3,
    REQ_SET_TIME = 3'd4
  } req_t;

  localparam int unsigned NUM_COLS = 23;
  localparam logic [4:0] LAST_COL   = 5'd22;
  localparam logic [4:0] H1_COL     = 5'd0;
  localparam logic [4:0] H2_COL     = 5'd5;
  localparam logic [4:0] BLANK_COL  = 5'd10;
  localparam logic [4:0] COLON_COL  = 5'd11;
  localparam logic [4:0] M1_COL     = 5'd12;
  localparam logic [4:0] M2_COL     = 5'd17;
  localparam logic [4:0] TAIL_COL   = 5'd22;
  localparam logic [7:0] COLON_BITS = 8'h24;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MIN_MAX    = 6'd59;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [2:0] GLYPH_MAX  = 3'd4;

  // Glyph columns for digits 0-9, bit r is row r.
  localparam logic [7:0] FONT [0:9][0:4] = '{
    '{8'h00, 8'h7F, 8'h41, 8'h41, 8'h7F},
    '{8'h00, 8'h00, 8'h04, 8'h02, 8'h7F},
    '{8'h00, 8'h79, 8'h49, 8'h49, 8'h4F},
    '{8'h00, 8'h49, 8'h49, 8'h49, 8'h7F},
    '{8'h00, 8'h0F, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h4F, 8'h49, 8'h49, 8'h79},
    '{8'h00, 8'h7F, 8'h49, 8'h49, 8'h79},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h7F},
    '{8'h00, 8'h7F, 8'h49, 8'h49, 8'h7F},
    '{8'h00, 8'h0F, 8'h09, 8'h09, 8'h7F}
  };

  // Controller to datapath.
  typedef struct packed {
    logic adv_min;
    logic adv_hour;
    logic set_time;
    logic col_clear;
    logic emit;
  } hhmm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic col_last;
  } hhmm_sts_t;

  // Tens digit of a value below 60.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd50)      t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [3:0] t);
    logic [5:0] base;
    base = {2'b00, t} * 6'd10;
    return 4'(v - base);
  endfunction

  function automatic logic [7:0] font_col(input logic [3:0] digit, input logic [2:0] off);
    logic [7:0] bits;
    if (digit > DIGIT_MAX || off > GLYPH_MAX) bits = 8'h00;
    else                                      bits = FONT[digit][off];
    return bits;
  endfunction

endpackage

// ----- rtl/core/hhmm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and column beats.
// Depends on nothing; used by the top level and the datapath.
interface hhmm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [4:0] new_hour;
  logic [5:0] new_minute;

  modport source (output valid, output req_type, output new_hour, output new_minute,
                  input ready);
  modport sink (input valid, input req_type, input new_hour, input new_minute,
                output ready);
endinterface

interface hhmm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] column_index;
  logic [7:0] column_bits;
  logic       last_column;

  modport source (output valid, output column_index, output column_bits,
                  output last_column, input ready);
  modport sink (input valid, input column_index, input column_bits,
                input last_column, output ready);
endinterface

// ----- rtl/core/hhmm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: decodes request beats and sequences the column sweep.
// Depends on hhmm_pkg.
module hhmm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_req_type,
  output logic                 in_ready,
  input  hhmm_pkg::hhmm_sts_t  sts,
  output hhmm_pkg::hhmm_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (hhmm_pkg::req_t'(in_req_type)) inside
            hhmm_pkg::REQ_MIN_TICK, hhmm_pkg::REQ_MIN_BTN: cmd.adv_min = 1'b1;
            hhmm_pkg::REQ_HOUR_BTN: cmd.adv_hour = 1'b1;
            hhmm_pkg::REQ_SET_TIME: cmd.set_time = 1'b1;
            hhmm_pkg::REQ_SWEEP: begin
              cmd.col_clear = 1'b1;
              state_nxt     = S_SWEEP;
            end
            default: ; // unused codes: drop
          endcase
        end
      end
      S_SWEEP: begin
        // advance one column whenever the output register can take it
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.col_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/hhmm_dp.sv -----
`timescale 1ns / 1ps
// Datapath: time registers, column counter, glyph lookup and output register.
// Depends on hhmm_pkg and hhmm_out_if.
module hhmm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          in_new_hour,
  input  logic [5:0]          in_new_minute,
  input  hhmm_pkg::hhmm_cmd_t cmd,
  output hhmm_pkg::hhmm_sts_t sts,
  hhmm_out_if.source          out_chan
);

  logic [4:0] hours_r, hours_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [4:0] col_r, col_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [4:0] out_index_r;
  logic [7:0] out_bits_r;
  logic       out_last_r;

  logic [3:0] h_tens, h_ones, m_tens, m_ones;
  logic [3:0] digit;
  logic [2:0] off;
  logic [7:0] col_bits;

  // Time update
  always_comb begin
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    if (cmd.adv_hour) begin
      hours_nxt = (hours_r >= hhmm_pkg::HOUR_MAX) ? 5'd0 : hours_r + 5'd1;
    end else if (cmd.adv_min) begin
      if (minutes_r >= hhmm_pkg::MIN_MAX) begin
        minutes_nxt = 6'd0;
        hours_nxt   = (hours_r >= hhmm_pkg::HOUR_MAX) ? 5'd0 : hours_r + 5'd1;
      end else begin
        minutes_nxt = minutes_r + 6'd1;
      end
    end else if (cmd.set_time) begin
      // ignore the whole load when either value is out of range
      if (in_new_hour <= hhmm_pkg::HOUR_MAX && in_new_minute <= hhmm_pkg::MIN_MAX) begin
        hours_nxt   = in_new_hour;
        minutes_nxt = in_new_minute;
      end
    end
  end

  // Column image
  always_comb begin
    h_tens = hhmm_pkg::tens_of({1'b0, hours_r});
    h_ones = hhmm_pkg::ones_of({1'b0, hours_r}, h_tens);
    m_tens = hhmm_pkg::tens_of(minutes_r);
    m_ones = hhmm_pkg::ones_of(minutes_r, m_tens);
    digit  = 4'd0;
    off    = 3'd0;
    col_bits = 8'h00;
    if (col_r < hhmm_pkg::H2_COL) begin
      digit    = h_tens;
      off      = 3'(col_r - hhmm_pkg::H1_COL);
      col_bits = hhmm_pkg::font_col(digit, off);
    end else if (col_r < hhmm_pkg::BLANK_COL) begin
      digit    = h_ones;
      off      = 3'(col_r - hhmm_pkg::H2_COL);
      col_bits = hhmm_pkg::font_col(digit, off);
    end else if (col_r == hhmm_pkg::COLON_COL) begin
      col_bits = hhmm_pkg::COLON_BITS;
    end else if (col_r >= hhmm_pkg::M1_COL && col_r < hhmm_pkg::M2_COL) begin
      digit    = m_tens;
      off      = 3'(col_r - hhmm_pkg::M1_COL);
      col_bits = hhmm_pkg::font_col(digit, off);
    end else if (col_r >= hhmm_pkg::M2_COL && col_r < hhmm_pkg::TAIL_COL) begin
      digit    = m_ones;
      off      = 3'(col_r - hhmm_pkg::M2_COL);
      col_bits = hhmm_pkg::font_col(digit, off);
    end
  end

  assign sts.out_free = !out_valid_r || out_chan.ready;
  assign sts.col_last = (col_r == hhmm_pkg::LAST_COL);

  always_comb begin
    col_nxt = col_r;
    if (cmd.col_clear)                 col_nxt = 5'd0;
    else if (cmd.emit && !sts.col_last) col_nxt = col_r + 5'd1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)            out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r     <= 5'd0;
      minutes_r   <= 6'd0;
      col_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index_r <= col_r;
      out_bits_r  <= col_bits;
      out_last_r  <= sts.col_last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.column_index = out_index_r;
  assign out_chan.column_bits  = out_bits_r;
  assign out_chan.last_column  = out_last_r;

endmodule

// ----- rtl/core/hhmm_clock_column_scan_display_core.sv -----
`timescale 1ns / 1ps
// HH:MM clock core: controller plus datapath behind valid/ready channels.
// Depends on hhmm_pkg, hhmm_if, hhmm_ctrl and hhmm_dp.
//
// Keeps a 24-hour time and scans an 8x23 LED image out one column per beat.
// Minute ticks, hour and minute buttons and set-time requests produce no
// output beat; an out-of-range set time leaves the time unchanged. A sweep
// request produces 23 column beats, columns 0 to 22, with last_column on
// the final one. The column counter steps once per cycle while the output
// register is free, so a sweep holds off the input until the final column
// has been loaded into the output register; no request is taken during a
// sweep. The output register holds the last column beat while the next
// request is taken.
module hhmm_clock_column_scan_display_core (
  input  logic        clk,
  input  logic        rst_n,
  hhmm_in_if.sink     in_chan,
  hhmm_out_if.source  out_chan
);

  hhmm_pkg::hhmm_cmd_t cmd;
  hhmm_pkg::hhmm_sts_t sts;
  logic                in_ready;

  assign in_chan.ready = in_ready;

  hhmm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  hhmm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_new_hour   (in_chan.new_hour),
    .in_new_minute (in_chan.new_minute),
    .cmd           (cmd),
    .sts           (sts),
    .out_chan      (out_chan)
  );

  // last_column flags exactly the final column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.last_column == (out_chan.column_index == hhmm_pkg::LAST_COL)))
    else $error("last_column does not match column_index");

  // a sweep request blocks further requests on the next cycle
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready && in_chan.req_type == hhmm_pkg::REQ_SWEEP) |=> !in_ready)
    else $error("request taken right after a sweep start");

  // columns are never emitted while idle
  a_emit_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ready)
    else $error("column emitted outside a sweep");

  // requests are only taken once the final column has been loaded
  a_resume_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(in_ready)) |-> (out_chan.valid && out_chan.last_column) || $past(cmd.emit && sts.col_last))
    else $error("sweep ended before the final column");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for hhmm_clock_column_scan_display_core: directed and random requests
// checked column by column against a time-of-day predictor kept in the bench.
// Depends on hhmm_pkg and hhmm_if from rtl/core and on the core itself.
module tb;

  localparam int DAY_HOURS     = 24;
  localparam int HOUR_MINUTES  = 60;
  localparam int SWEEP_COLS    = 23;
  localparam int HOUR_DIGIT2   = 5;
  localparam int DARK_GAP_COL  = 10;
  localparam int DOTS_COL      = 11;
  localparam int MIN_DIGIT1    = 12;
  localparam int MIN_DIGIT2    = 17;
  localparam int TRAIL_COL     = 22;
  localparam logic [7:0] DOTS_ROWS = 8'h24;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int LONG_STALL     = 160;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // Digit glyphs, five columns each, bit r lights row r.
  localparam logic [7:0] DIGIT_GLYPH [10][5] = '{
    '{8'h00, 8'h7F, 8'h41, 8'h41, 8'h7F},
    '{8'h00, 8'h00, 8'h04, 8'h02, 8'h7F},
    '{8'h00, 8'h79, 8'h49, 8'h49, 8'h4F},
    '{8'h00, 8'h49, 8'h49, 8'h49, 8'h7F},
    '{8'h00, 8'h0F, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h4F, 8'h49, 8'h49, 8'h79},
    '{8'h00, 8'h7F, 8'h49, 8'h49, 8'h79},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h7F},
    '{8'h00, 8'h7F, 8'h49, 8'h49, 8'h7F},
    '{8'h00, 8'h0F, 8'h09, 8'h09, 8'h7F}
  };

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] rows;
    logic       last;
  } column_beat_t;

  logic clk;
  logic rst_n;

  hhmm_in_if  in_chan ();
  hhmm_out_if out_chan ();

  hhmm_clock_column_scan_display_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predicted time of day and the columns still owed by the block.
  int unsigned  clock_hours;
  int unsigned  clock_minutes;
  column_beat_t column_q [$];

  int fail_count;
  int burst_left;
  bit sender_idles;
  bit stall_request;
  int stall_left;
  int rx_count;
  int rx_mode;
  int idle_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [7:0] glyph_rows(input int unsigned digit, input int unsigned off);
    return DIGIT_GLYPH[digit][off];
  endfunction

  function automatic logic [7:0] image_column(input int unsigned col);
    logic [7:0] rows;
    rows = 8'h00;
    if (col < HOUR_DIGIT2)
      rows = glyph_rows(clock_hours / 10, col);
    else if (col < DARK_GAP_COL)
      rows = glyph_rows(clock_hours % 10, col - HOUR_DIGIT2);
    else if (col == DOTS_COL)
      rows = DOTS_ROWS;
    else if (col >= MIN_DIGIT1 && col < MIN_DIGIT2)
      rows = glyph_rows(clock_minutes / 10, col - MIN_DIGIT1);
    else if (col >= MIN_DIGIT2 && col < TRAIL_COL)
      rows = glyph_rows(clock_minutes % 10, col - MIN_DIGIT2);
    return rows;
  endfunction

  function automatic void step_hour();
    clock_hours = (clock_hours + 1) % DAY_HOURS;
  endfunction

  function automatic void step_minute();
    if (clock_minutes == HOUR_MINUTES - 1) begin
      clock_minutes = 0;
      step_hour();
    end else begin
      clock_minutes++;
    end
  endfunction

  // Update the predicted time and queue the columns for one accepted request.
  function automatic void apply_request(input logic [2:0] rt, input logic [4:0] nh,
                                        input logic [5:0] nm);
    column_beat_t beat;
    case (rt)
      hhmm_pkg::REQ_MIN_TICK, hhmm_pkg::REQ_MIN_BTN: step_minute();
      hhmm_pkg::REQ_HOUR_BTN: step_hour();
      hhmm_pkg::REQ_SWEEP: begin
        for (int c = 0; c < SWEEP_COLS; c++) begin
          beat.idx  = 5'(c);
          beat.rows = image_column(c);
          beat.last = (c == SWEEP_COLS - 1);
          column_q.push_back(beat);
        end
      end
      hhmm_pkg::REQ_SET_TIME: begin
        if (nh < DAY_HOURS && nm < HOUR_MINUTES) begin
          clock_hours   = nh;
          clock_minutes = nm;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [2:0] rt, input logic [4:0] nh, input logic [5:0] nm);
    int gap;
    gap = 0;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(1, 6);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= rt;
    in_chan.new_hour   <= nh;
    in_chan.new_minute <= nm;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(rt, nh, nm);
  endtask

  // Hold the sender until every owed column has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (column_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_image();
    send_req(hhmm_pkg::REQ_SWEEP, 5'd0, 6'd0);
  endtask

  task automatic test_day_wrap();
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd23, 6'd59);
    send_req(hhmm_pkg::REQ_MIN_TICK, 5'd31, 6'd63);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd23, 6'd59);
    send_req(hhmm_pkg::REQ_MIN_BTN, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd31, 6'd63);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd23, 6'd0);
    send_req(hhmm_pkg::REQ_HOUR_BTN, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd19, 6'd59);
    send_req(hhmm_pkg::REQ_HOUR_BTN, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_MIN_BTN, 5'd0, 6'd0);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd0, 6'd0);
  endtask

  task automatic test_bad_requests();
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd12, 6'd34);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd24, 6'd0);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd0, 6'd60);
    send_req(hhmm_pkg::REQ_SET_TIME, 5'd31, 6'd63);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd0, 6'd0);
    for (logic [3:0] rt = REQ_SPARE_LO; rt <= REQ_SPARE_HI; rt++)
      send_req(rt[2:0], 5'd31, 6'd63);
    send_req(hhmm_pkg::REQ_SWEEP, 5'd31, 6'd63);
  endtask

  task automatic send_random_req();
    int pick;
    logic [4:0] nh;
    logic [5:0] nm;
    pick = $urandom_range(0, 99);
    nh = 5'($urandom);
    nm = 6'($urandom);
    if (pick < 25)
      send_req(hhmm_pkg::REQ_SWEEP, nh, nm);
    else if (pick < 43)
      send_req(hhmm_pkg::REQ_MIN_TICK, nh, nm);
    else if (pick < 53)
      send_req(hhmm_pkg::REQ_HOUR_BTN, nh, nm);
    else if (pick < 66)
      send_req(hhmm_pkg::REQ_MIN_BTN, nh, nm);
    else if (pick < 76)
      send_req(hhmm_pkg::REQ_SET_TIME, 5'($urandom_range(0, DAY_HOURS - 1)),
               6'($urandom_range(0, HOUR_MINUTES - 1)));
    else if (pick < 84)
      // land next to a carry so ticks and buttons reach the wraps
      send_req(hhmm_pkg::REQ_SET_TIME, 5'($urandom_range(DAY_HOURS - 3, DAY_HOURS - 1)),
               6'($urandom_range(HOUR_MINUTES - 3, HOUR_MINUTES - 1)));
    else if (pick < 95)
      send_req(hhmm_pkg::REQ_SET_TIME, nh, nm);
    else
      send_req(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), nh, nm);
  endtask

  task automatic test_random_traffic(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0)
        sender_idles = ($urandom_range(0, 3) != 0);
      if (i == n_items / 2)
        wait_drain();
      send_random_req();
    end
  endtask

  task automatic test_output_backpressure();
    stall_request = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_req(hhmm_pkg::REQ_SWEEP, 5'($urandom), 6'($urandom));
      send_req(hhmm_pkg::REQ_MIN_TICK, 5'($urandom), 6'($urandom));
    end
    wait_drain();
  endtask

  // Receiver: rotate through stall patterns, honor a long hold when asked.
  always @(negedge clk) begin
    rx_count++;
    if (rx_count % 60 == 0)
      rx_mode = $urandom_range(0, 3);
    if (stall_request) begin
      stall_left = LONG_STALL;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom_range(0, 1));
        2: out_chan.ready <= (rx_count % 4 != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Compare each column beat with the oldest owed column.
  always @(posedge clk) begin
    column_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (column_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected column beat: idx %0d rows %h last %b",
                   out_chan.column_index, out_chan.column_bits, out_chan.last_column);
      end else begin
        want = column_q.pop_front();
        if (out_chan.column_index !== want.idx || out_chan.column_bits !== want.rows ||
            out_chan.last_column !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"column mismatch: expected idx %0d rows %h last %b, ",
                      "got idx %0d rows %h last %b"},
                     want.idx, want.rows, want.last, out_chan.column_index,
                     out_chan.column_bits, out_chan.last_column);
        end
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.req_type   = hhmm_pkg::REQ_MIN_TICK;
    in_chan.new_hour   = 5'd0;
    in_chan.new_minute = 6'd0;
    out_chan.ready     = 1'b0;
    clock_hours   = 0;
    clock_minutes = 0;
    fail_count    = 0;
    burst_left    = 0;
    sender_idles  = 1'b1;
    stall_request = 1'b0;
    stall_left    = 0;
    rx_count      = 0;
    rx_mode       = 0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_image();
    test_day_wrap();
    test_bad_requests();
    wait_drain();
    test_output_backpressure();
    test_random_traffic(300);
    wait_drain();
    repeat (40) @(posedge clk);

    if (fail_count == 0 && column_q.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
